// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned OutQOccW = 2;
  localparam logic [OutQOccW-1:0] OutQFull = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_DUMP    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REV,
    S_DUMP,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic signed [ValueW-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] entry_value;
    logic                     found;
    logic [CountW-1:0]        entry_count;
    logic                     last_of_run;
    logic                     insert_rejected;
    logic                     list_empty;
  } out_item_t;

  // Port enables of the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Fill level of the result queue and whether a beat leaves this cycle.
  typedef struct packed {
    logic [OutQOccW-1:0] occ;
    logic                pop;
  } outq_stat_t;

endpackage

// File: rtl/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed 32-bit values held in a single-port-pair memory.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the input channel (valid/stall) and results
// leave as beats on the output channel. Insert appends, remove deletes the
// first equal entry and closes the gap, search reports presence, reverse
// flips the order and dump returns every entry in order, last one marked.
// Every result carries the entry count after the command.
// One command is worked on at a time; the input stalls until the command's
// last result has been placed in the two-beat result queue.
// Work per command, set by the one read and one write port:
//   insert and unused codes: no store read; the result is queued from S_RESULT.
//   search and remove: one memory read per entry.
//   reverse: two reads per swapped pair.
//   dump: one read and one beat per cycle while the result queue has room.
// When the receiver stalls, the queue fills and the dump walk pauses.
// Reset empties the list; the store itself is not cleared and no entry
// beyond the count is ever read.
// ----------------------------------------------------------------------------
module array_list_engine
  import ale_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW = $clog2(LIST_DEPTH);
  localparam int unsigned CntW  = $clog2(LIST_DEPTH + 1);

  mem_ctl_t                 mem_ctl;
  logic [AddrW-1:0]         rd_addr;
  logic [AddrW-1:0]         wr_addr;
  logic signed [ValueW-1:0] wr_data;
  logic signed [ValueW-1:0] rd_data;
  outq_stat_t               outq_stat;
  logic                     push;
  out_item_t                push_data;

  ale_ctrl #(
    .Depth(LIST_DEPTH),
    .AddrW(AddrW),
    .CntW (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .mem_ctl_o  (mem_ctl),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_data_i  (rd_data),
    .outq_i     (outq_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  ale_store #(
    .Depth(LIST_DEPTH),
    .AddrW(AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_data_o(rd_data)
  );

  ale_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .stat_o     (outq_stat)
  );

endmodule

// File: rtl/ale_store.sv
// ----------------------------------------------------------------------------
// ale_store
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ale_store
  import ale_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                     clk_i,
  input  mem_ctl_t                 ctl_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic signed [ValueW-1:0] wr_data_i,
  output logic signed [ValueW-1:0] rd_data_o
);

  logic signed [ValueW-1:0] mem [Depth];
  logic signed [ValueW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/ale_outq.sv
// ----------------------------------------------------------------------------
// ale_outq
// Two-slot result queue that decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
module ale_outq
  import ale_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_item_t  push_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  output outq_stat_t stat_o
);

  out_item_t           slot_q [2];
  logic                wr_q, wr_d;
  logic                rd_q, rd_d;
  logic [OutQOccW-1:0] occ_q, occ_d;
  logic                pop;

  assign out_valid_o = (occ_q != '0);
  assign out_data_o  = slot_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    occ_d = occ_q + OutQOccW'(push_i) - OutQOccW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      occ_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  assign stat_o.occ = occ_q;
  assign stat_o.pop = pop;

endmodule

// File: rtl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Command sequencer: walks the store one read per cycle (a dump waits for room
// in the result queue) and writes entries back for remove and reverse.
// ----------------------------------------------------------------------------
module ale_ctrl
  import ale_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned CntW  = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output mem_ctl_t                 mem_ctl_o,
  output logic [AddrW-1:0]         rd_addr_o,
  output logic [AddrW-1:0]         wr_addr_o,
  output logic signed [ValueW-1:0] wr_data_o,
  input  logic signed [ValueW-1:0] rd_data_i,
  input  outq_stat_t               outq_i,
  output logic                     push_o,
  output out_item_t                push_data_o
);

  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  state_e                   state_q, state_d;
  cmd_e                     cmd_q, cmd_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [CntW-1:0]          ptr_q, ptr_d;
  logic                     ph_q, ph_d;
  logic                     match_q, match_d;
  logic                     rej_q, rej_d;
  logic                     empty_q, empty_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]         rd_idx_q, rd_idx_d;
  logic                     rd_sec_q, rd_sec_d;
  logic [AddrW-1:0]         h_addr_q, h_addr_d;
  logic signed [ValueW-1:0] h_data_q, h_data_d;
  logic                     pend_vld_q, pend_vld_d;
  logic [AddrW-1:0]         pend_addr_q, pend_addr_d;
  logic signed [ValueW-1:0] pend_data_q, pend_data_d;

  logic            accept;
  cmd_e            in_cmd;
  logic            issue_more;
  logic [CntW-1:0] half;
  logic [CntW-1:0] mirror;
  logic            last_arr;
  logic            hit;
  logic            space_ok;
  logic            res_ok;
  logic            rev_done;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_cmd     = cmd_e'(in_data_i.command);
  assign issue_more = (ptr_q < cnt_q);
  assign half       = cnt_q >> 1;
  assign mirror     = cnt_q - OneCnt - ptr_q;
  assign last_arr   = rd_vld_q && (CntW'(rd_idx_q) == (cnt_q - OneCnt));
  assign hit        = (rd_data_i == val_q);
  // Keep at most two beats queued or in flight, counting the one leaving now.
  assign space_ok   = ({1'b0, outq_i.occ} + 3'(rd_vld_q)) < (3'd2 + 3'(outq_i.pop));
  assign res_ok     = (outq_i.occ != OutQFull);
  assign rev_done   = (ptr_q == half) && !rd_vld_q && !pend_vld_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd) inside
            CMD_REMOVE, CMD_SEARCH: state_d = (cnt_q == '0) ? S_RESULT : S_SCAN;
            CMD_REVERSE:            state_d = (cnt_q < CntW'(2)) ? S_RESULT : S_REV;
            CMD_DUMP:               state_d = (cnt_q == '0) ? S_RESULT : S_DUMP;
            default:                state_d = S_RESULT;
          endcase
        end
      end
      S_SCAN:   if (last_arr) state_d = S_RESULT;
      S_REV:    if (rev_done) state_d = S_RESULT;
      S_DUMP:   if (last_arr) state_d = S_IDLE;
      S_RESULT: if (res_ok) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and store accesses.
  always_comb begin
    cmd_d       = cmd_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    ph_d        = ph_q;
    match_d     = match_q;
    rej_d       = rej_q;
    empty_d     = empty_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    rd_sec_d    = rd_sec_q;
    h_addr_d    = h_addr_q;
    h_data_d    = h_data_q;
    pend_vld_d  = pend_vld_q;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    mem_ctl_o   = '0;
    rd_addr_o   = ptr_q[AddrW-1:0];
    wr_addr_o   = cnt_q[AddrW-1:0];
    wr_data_o   = in_data_i.operand_value;
    push_o      = 1'b0;
    push_data_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = in_cmd;
          val_d   = in_data_i.operand_value;
          ptr_d   = '0;
          ph_d    = 1'b0;
          match_d = 1'b0;
          rej_d   = 1'b0;
          empty_d = (in_cmd == CMD_DUMP) && (cnt_q == '0);
          if (in_cmd == CMD_INSERT) begin
            if (cnt_q < DepthCnt) begin
              mem_ctl_o.wr_en = 1'b1;
              cnt_d           = cnt_q + OneCnt;
            end else begin
              rej_d = 1'b1;
            end
          end
        end
      end

      S_SCAN: begin
        if (issue_more) begin
          mem_ctl_o.rd_en = 1'b1;
          rd_vld_d        = 1'b1;
          rd_idx_d        = ptr_q[AddrW-1:0];
          ptr_d           = ptr_q + OneCnt;
        end
        if (rd_vld_q) begin
          // For remove, every entry past the first match moves down one place.
          if (match_q && (cmd_q == CMD_REMOVE)) begin
            mem_ctl_o.wr_en = 1'b1;
            wr_addr_o       = rd_idx_q - AddrW'(1);
            wr_data_o       = rd_data_i;
          end
          if (hit) begin
            match_d = 1'b1;
          end
          if (last_arr && (match_q || hit) && (cmd_q == CMD_REMOVE)) begin
            cnt_d = cnt_q - OneCnt;
          end
        end
      end

      S_REV: begin
        if (ptr_q < half) begin
          mem_ctl_o.rd_en = 1'b1;
          rd_vld_d        = 1'b1;
          rd_sec_d        = ph_q;
          rd_addr_o       = ph_q ? mirror[AddrW-1:0] : ptr_q[AddrW-1:0];
          rd_idx_d        = rd_addr_o;
          ph_d            = !ph_q;
          if (ph_q) begin
            ptr_d = ptr_q + OneCnt;
          end
        end
        if (rd_vld_q && !rd_sec_q) begin
          h_addr_d = rd_idx_q;
          h_data_d = rd_data_i;
        end
        // The lower entry of a pair is written when the upper one arrives,
        // the upper entry in the following cycle.
        if (rd_vld_q && rd_sec_q) begin
          mem_ctl_o.wr_en = 1'b1;
          wr_addr_o       = h_addr_q;
          wr_data_o       = rd_data_i;
          pend_vld_d      = 1'b1;
          pend_addr_d     = rd_idx_q;
          pend_data_d     = h_data_q;
        end else if (pend_vld_q) begin
          mem_ctl_o.wr_en = 1'b1;
          wr_addr_o       = pend_addr_q;
          wr_data_o       = pend_data_q;
          pend_vld_d      = 1'b0;
        end
      end

      S_DUMP: begin
        if (issue_more && space_ok) begin
          mem_ctl_o.rd_en = 1'b1;
          rd_vld_d        = 1'b1;
          rd_idx_d        = ptr_q[AddrW-1:0];
          ptr_d           = ptr_q + OneCnt;
        end
        if (rd_vld_q) begin
          push_o                  = 1'b1;
          push_data_o.entry_value = rd_data_i;
          push_data_o.entry_count = CountW'(cnt_q);
          push_data_o.last_of_run = last_arr;
        end
      end

      S_RESULT: begin
        if (res_ok) begin
          push_o                      = 1'b1;
          push_data_o.found           = match_q;
          push_data_o.entry_count     = CountW'(cnt_q);
          push_data_o.last_of_run     = 1'b1;
          push_data_o.insert_rejected = rej_q;
          push_data_o.list_empty      = empty_q;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      ptr_q      <= '0;
      ph_q       <= 1'b0;
      match_q    <= 1'b0;
      rej_q      <= 1'b0;
      empty_q    <= 1'b0;
      rd_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      cmd_q      <= CMD_INSERT;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      ph_q       <= ph_d;
      match_q    <= match_d;
      rej_q      <= rej_d;
      empty_q    <= empty_d;
      rd_vld_q   <= rd_vld_d;
      pend_vld_q <= pend_vld_d;
      cmd_q      <= cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    rd_idx_q    <= rd_idx_d;
    rd_sec_q    <= rd_sec_d;
    h_addr_q    <= h_addr_d;
    h_data_q    <= h_data_d;
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

endmodule

// File: rtl/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks of the array list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ale_checker
  import ale_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Commands are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a command is in progress");

  // A rejected insert only happens on a full list and ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.insert_rejected |->
      out_data_o.last_of_run && (out_data_o.entry_count == 7'(LIST_DEPTH)))
    else $error("insert rejected below capacity");

  // The empty-dump beat carries no entry and a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.list_empty |->
      out_data_o.last_of_run && (out_data_o.entry_count == '0) &&
      (out_data_o.entry_value == '0))
    else $error("malformed empty-list beat");

  // A found beat ends its command and never carries an entry value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |->
      out_data_o.last_of_run && (out_data_o.entry_value == '0))
    else $error("found beat carries an entry value");

endmodule

bind array_list_engine ale_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ale_checker (.*);
